// ===== rtl/core/timestamp_gated_send_queue_core_defines.svh =====
// Assertion macros used by the checker file of the send queue core.
`ifndef TIMESTAMP_GATED_SEND_QUEUE_CORE_DEFINES_SVH
`define TIMESTAMP_GATED_SEND_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define TGSQ_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define TGSQ_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tgsq_pkg.sv =====
package tgsq_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 16;
    localparam int unsigned HANDLE_W       = 16;
    localparam int unsigned STAMP_W        = 32;
    localparam int unsigned CFG_W          = 32;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRI       = 2'd2;

    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_RELEASED = 2'd2,
        KIND_DONE     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_BROADCAST  = 2'd0,
        MODE_UNICAST    = 2'd1,
        MODE_TRIANGULAR = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PROBE,
        BK_SCAN,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic [STAMP_W-1:0] threshold;
        logic               has_peer;
        logic               tri_mode;
    } t_cfg;

    typedef struct packed {
        t_action             action;
        logic [HANDLE_W-1:0] handle;
        logic [STAMP_W-1:0]  now;
    } t_item;

    typedef struct packed {
        t_kind               kind;
        logic [HANDLE_W-1:0] handle;
        t_mode               mode;
        logic                last;
    } t_result;

    // Triangular routing only applies when a unicast peer exists.
    function automatic t_mode send_mode(input t_cfg cfg);
        t_mode mode;
        if (cfg.has_peer && cfg.tri_mode) begin
            mode = MODE_TRIANGULAR;
        end else if (cfg.has_peer) begin
            mode = MODE_UNICAST;
        end else begin
            mode = MODE_BROADCAST;
        end
        return mode;
    endfunction

endpackage

// ===== rtl/core/tgsq_if.sv =====
interface tgsq_in_if import tgsq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [HANDLE_W-1:0] msg_handle;
    logic [STAMP_W-1:0]  now_time;

    modport source (output valid, action, msg_handle, now_time, input ready);
    modport sink   (input valid, action, msg_handle, now_time, output ready);
endinterface

interface tgsq_out_if import tgsq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          result_kind;
    logic [HANDLE_W-1:0] out_handle;
    logic [1:0]          send_mode;
    logic                last;

    modport source (output valid, result_kind, out_handle, send_mode, last, input ready);
    modport sink   (input valid, result_kind, out_handle, send_mode, last, output ready);
endinterface

// ===== rtl/core/tgsq_ram.sv =====
module tgsq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tgsq_front.sv =====
module tgsq_front import tgsq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tgsq_in_if.sink i_req,
    output t_item  o_item,
    output logic   o_item_valid,
    input  logic   i_item_ready
);

    t_item             r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_fill, n_fill;
    logic              push;
    logic              pop;
    t_item             in_item;

    // Classify the transfer into an action code as it enters the queue.
    always_comb begin
        in_item.action = i_req.action ? ACT_RELEASE : ACT_ENQUEUE;
        in_item.handle = i_req.msg_handle;
        in_item.now    = i_req.now_time;
    end

    assign i_req.ready  = (r_fill != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push         = i_req.valid && i_req.ready;
    assign o_item_valid = (r_fill != '0);
    assign pop          = o_item_valid && i_item_ready;
    assign o_item       = r_buf[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= in_item;
        end
    end

endmodule

// ===== rtl/core/tgsq_back.sv =====
module tgsq_back import tgsq_pkg::*; #(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_item_valid,
    output logic        o_item_ready,
    input  t_cfg        i_cfg,
    tgsq_out_if.source  o_rsp
);

    localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
    localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int unsigned ROW_W  = HANDLE_W + STAMP_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(SLOT_COUNT);

    t_back_state           r_state, n_state;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic [SLOT_W-1:0]     r_cursor, n_cursor;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [HANDLE_W-1:0]   r_handle, n_handle;
    logic [STAMP_W-1:0]    r_now, n_now;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;

    logic                  out_free;
    logic                  ram_we;
    logic [ROW_W-1:0]      ram_rdata;
    logic [HANDLE_W-1:0]   row_handle;
    logic [STAMP_W-1:0]    row_stamp;
    logic                  eligible;

    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] idx);
        return (idx == LAST_SLOT) ? '0 : idx + SLOT_W'(1);
    endfunction

    // Read address follows the next index, so the registered row always
    // matches r_idx, also across a stall.
    tgsq_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata ({r_handle, r_now}),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    assign row_handle = ram_rdata[ROW_W-1 -: HANDLE_W];
    assign row_stamp  = ram_rdata[STAMP_W-1:0];
    assign eligible   = r_valid[r_idx] && (row_stamp <= i_cfg.threshold);
    assign out_free   = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_cursor     = r_cursor;
        n_count      = r_count;
        n_idx        = r_idx;
        n_handle     = r_handle;
        n_now        = r_now;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out        = r_out;
        ram_we       = 1'b0;
        o_item_ready = 1'b0;

        case (r_state)
            BK_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_handle = i_item.handle;
                    n_now    = i_item.now;
                    if (i_item.action == ACT_RELEASE) begin
                        n_idx   = '0;
                        n_state = BK_SCAN;
                    end else begin
                        n_idx   = r_cursor;
                        n_state = BK_PROBE;
                    end
                end
            end
            BK_PROBE: begin
                if (r_count == FULL_CNT) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '{KIND_REJECTED, '0, MODE_BROADCAST, 1'b1};
                        n_state     = BK_IDLE;
                    end
                end else if (!r_valid[r_idx]) begin
                    if (out_free) begin
                        ram_we         = 1'b1;
                        n_valid[r_idx] = 1'b1;
                        n_cursor       = r_idx;
                        n_count        = r_count + CNT_W'(1);
                        n_out_valid    = 1'b1;
                        n_out          = '{KIND_ACCEPTED, r_handle, MODE_BROADCAST, 1'b1};
                        n_state        = BK_IDLE;
                    end
                end else begin
                    n_idx = wrap_inc(r_idx);
                end
            end
            BK_SCAN: begin
                if (!eligible || out_free) begin
                    if (eligible) begin
                        n_valid[r_idx] = 1'b0;
                        n_count        = r_count - CNT_W'(1);
                        n_out_valid    = 1'b1;
                        n_out          = '{KIND_RELEASED, row_handle, send_mode(i_cfg), 1'b0};
                    end
                    if (r_idx == LAST_SLOT) begin
                        n_state = BK_DONE;
                    end else begin
                        n_idx = wrap_inc(r_idx);
                    end
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{KIND_DONE, '0, MODE_BROADCAST, 1'b1};
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_valid     <= '0;
            r_cursor    <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_cursor    <= n_cursor;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_handle <= n_handle;
        r_now    <= n_now;
        r_out    <= n_out;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_kind = r_out.kind;
    assign o_rsp.out_handle  = r_out.handle;
    assign o_rsp.send_mode   = r_out.mode;
    assign o_rsp.last        = r_out.last;

endmodule

// ===== rtl/core/timestamp_gated_send_queue_core.sv =====
// Timestamp-gated send queue: a table of SLOT_COUNT message handles, each
// stamped with the time at which it was queued.
// i_req carries one request per transfer: action 0 queues msg_handle with
// now_time, action 1 releases every held slot whose stamp is at most the
// release threshold. o_rsp returns the results: one accepted or rejected-full
// result for a queue request; for a release one result per freed slot in
// ascending slot order, then a done marker. last marks the final result.
// Configuration (threshold, unicast peer, triangular routing) is to be
// written through i_cfg_we / i_cfg_idx / i_cfg_data only while the block is
// idle; the block itself does not enforce this. A queue request probes from
// the cursor past occupied slots to the first free one and is rejected when
// the table is full. A release visits every slot, then gives its done marker.
// The back end handles one request at a time and visits one slot per cycle
// unless o_rsp holds a result back, bounded by the single read port of the
// slot memory. A two-entry queue takes further requests while the back end
// is busy. Reset clears all slots, the cursor, the count and the
// configuration (threshold all ones, broadcast). When o_rsp stalls, the result
// register holds and the back end waits; nothing is lost.
module timestamp_gated_send_queue_core import tgsq_pkg::*; #(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tgsq_in_if.sink              i_req,
    tgsq_out_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg  r_cfg, n_cfg;
    t_item item;
    logic  item_valid;
    logic  item_ready;

    // Configuration registers; an unknown index drops the write.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: n_cfg.threshold = i_cfg_data[STAMP_W-1:0];
                CFG_PEER:      n_cfg.has_peer  = i_cfg_data[0];
                CFG_TRI:       n_cfg.tri_mode  = i_cfg_data[0];
                default:       n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{threshold: '1, has_peer: 1'b0, tri_mode: 1'b0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front: take each transfer, tag its action and queue it.
    tgsq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready)
    );

    // Back: probe or scan the slot table, one slot per cycle unless o_rsp stalls.
    tgsq_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_ready (item_ready),
        .i_cfg        (r_cfg),
        .o_rsp        (o_rsp)
    );

endmodule

// ===== rtl/core/tgsq_checker.sv =====
`include "timestamp_gated_send_queue_core_defines.svh"

module tgsq_checker import tgsq_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [1:0]          i_rsp_kind,
    input logic [HANDLE_W-1:0] i_rsp_handle,
    input logic [1:0]          i_rsp_mode,
    input logic                i_rsp_last
);

    // Hold a stalled result.
    `TGSQ_ASSERT_NXT(a_rsp_hold, i_clk, !i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_kind) && $stable(i_rsp_handle) && $stable(i_rsp_mode) && $stable(i_rsp_last), "stalled result changed")

    // Leave reset with no result pending and room for a request.
    `TGSQ_ASSERT_NXT(a_reset_quiet, i_clk, 1'b0, !i_rst_n, !i_rsp_valid && i_req_ready, "not quiet after reset")

    `TGSQ_ASSERT_IMP(a_done_form, i_clk, !i_rst_n, i_rsp_valid && (i_rsp_kind == KIND_DONE), i_rsp_last && (i_rsp_handle == '0) && (i_rsp_mode == MODE_BROADCAST), "malformed done marker")

    `TGSQ_ASSERT_IMP(a_release_form, i_clk, !i_rst_n, i_rsp_valid && (i_rsp_kind == KIND_RELEASED), !i_rsp_last && ((i_rsp_mode == MODE_BROADCAST) || (i_rsp_mode == MODE_UNICAST) || (i_rsp_mode == MODE_TRIANGULAR)), "malformed released entry")

    `TGSQ_ASSERT_IMP(a_queue_form, i_clk, !i_rst_n, i_rsp_valid && ((i_rsp_kind == KIND_ACCEPTED) || (i_rsp_kind == KIND_REJECTED)), i_rsp_last && (i_rsp_mode == MODE_BROADCAST), "malformed queue answer")

endmodule

bind timestamp_gated_send_queue_core tgsq_checker u_tgsq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_kind   (o_rsp.result_kind),
    .i_rsp_handle (o_rsp.out_handle),
    .i_rsp_mode   (o_rsp.send_mode),
    .i_rsp_last   (o_rsp.last)
);
